// ===== hdl/efd_pkg.sv =====
// Shared constants, types and the result word format of the escaped frame deframer.
package efd_pkg;

    localparam logic [7:0] START_CODE       = 8'hFF;
    localparam logic [7:0] STOP_CODE        = 8'hFE;
    localparam logic [7:0] ESC_CODE         = 8'h80;
    localparam logic [7:0] TYPE_LIMIT_RESET = 8'd16;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2,
        PH_ESC  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
        logic [7:0] frame_type;
        logic       type_known;
        logic       dangling_escape;
    } efd_result_t;

endpackage

// ===== hdl/efd_in_reg.sv =====
// Input register stage that holds one received byte until the decoder consumes it.
module efd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_byte
);
    import efd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The held word leaves when the decoder can move it on, so a new word may enter
    // in the same cycle.
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

// ===== hdl/efd_core.sv =====
// Frame state machine that turns one held byte into at most one result word.
module efd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic [7:0]         item_byte,
    input  logic               advance,
    input  logic [7:0]         type_limit,
    output logic               res_valid,
    output efd_pkg::efd_result_t res
);
    import efd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] type_hold_reg;
    logic [7:0] type_hold_next;
    logic       fire;
    logic       known;
    logic       is_stop;
    logic       is_start;
    logic       is_esc;

    assign fire     = item_valid && advance;
    assign is_stop  = (item_byte == STOP_CODE);
    assign is_start = (item_byte == START_CODE);
    assign is_esc   = (item_byte == ESC_CODE);
    assign known    = (type_hold_reg != 8'd0) && (type_hold_reg < type_limit);

    always_comb
    begin
        phase_next     = phase_reg;
        type_hold_next = type_hold_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (is_start)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (is_stop)
                    begin
                        type_hold_next = 8'd0;
                        phase_next     = PH_HUNT;
                    end
                    else
                    begin
                        type_hold_next = item_byte;
                        phase_next     = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (is_stop)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else if (is_esc)
                    begin
                        phase_next = PH_ESC;
                    end
                end
                PH_ESC:
                begin
                    phase_next = is_stop ? PH_HUNT : PH_BODY;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                res_valid = 1'b0;
            end
            PH_TYPE:
            begin
                res_valid     = item_valid && is_stop;
                res.frame_end = 1'b1;
            end
            PH_BODY:
            begin
                res_valid      = item_valid && !is_esc;
                res.frame_type = type_hold_reg;
                res.type_known = known;
                if (is_stop)
                begin
                    res.frame_end = 1'b1;
                end
                else
                begin
                    res.is_data  = 1'b1;
                    res.out_byte = item_byte;
                end
            end
            PH_ESC:
            begin
                res_valid      = item_valid;
                res.frame_type = type_hold_reg;
                res.type_known = known;
                if (is_stop)
                begin
                    res.frame_end       = 1'b1;
                    res.dangling_escape = 1'b1;
                end
                else
                begin
                    res.is_data  = 1'b1;
                    res.out_byte = ESC_CODE + item_byte;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            type_hold_reg <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            type_hold_reg <= type_hold_next;
        end
    end

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.is_data != res.frame_end))
        else $error("result word is neither data nor end, or both");

    a_dangle_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.dangling_escape) |-> (res.frame_end && phase_reg == PH_ESC))
        else $error("dangling escape flagged outside an escaped stop");

    a_stop_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_stop && phase_reg != PH_HUNT) |=> (phase_reg == PH_HUNT))
        else $error("stop byte did not close the frame");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_stop && phase_reg == PH_TYPE) |=> (type_hold_reg == 8'd0))
        else $error("empty frame left a stale type");

endmodule

// ===== hdl/efd_out_reg.sv =====
// Result register that holds one result word until the consumer takes it.
module efd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  efd_pkg::efd_result_t res,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output efd_pkg::efd_result_t out_word
);
    import efd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    efd_result_t word_reg;

    // There is room when the register is empty or its word is taken this cycle.
    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && room)
        begin
            word_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/escaped_frame_deframer.sv =====
// Top level of the escaped frame deframer: input register, frame decoder, result register.
// A byte accepted into the input register is decoded combinationally, and its result word is
// registered in the result register, which drives out_valid.
// Throughput: one byte per clock; the input register and the result register each pass a word
// on in the cycle they receive room, so the stream does not stall while out_ready stays high.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the decoder to
// hunting for a start byte with a zero type, and sets type_limit to 16.
module escaped_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       type_limit_we,
    input  logic [7:0] type_limit_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       frame_end,
    output logic [7:0] frame_type,
    output logic       type_known,
    output logic       dangling_escape
);
    import efd_pkg::*;

    logic [7:0]  type_limit_reg;
    logic        item_valid;
    logic [7:0]  item_byte;
    logic        room;
    logic        res_valid;
    efd_result_t res;
    efd_result_t out_word;

    // The type limit is a plain register; software must write it only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_limit_reg <= TYPE_LIMIT_RESET;
        end
        else if (type_limit_we)
        begin
            type_limit_reg <= type_limit_wdata;
        end
    end

    // The held byte moves on whenever the result register has room. A byte that makes no
    // result, such as one dropped while hunting or the type byte, still needs room here; the
    // result register empties every cycle out_ready is high, so this costs no throughput.
    efd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (room),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    // The decoder keeps the frame phase and the type byte and forms the result word from the
    // held byte with a compare or an 8-bit add.
    efd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .advance    (room),
        .type_limit (type_limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    efd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid && item_valid),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign out_byte        = out_word.out_byte;
    assign is_data         = out_word.is_data;
    assign frame_end       = out_word.frame_end;
    assign frame_type      = out_word.frame_type;
    assign type_known      = out_word.type_known;
    assign dangling_escape = out_word.dangling_escape;

endmodule

// ===== verif/escaped_frame_deframer_tb.sv =====
// Self-checking testbench for the escaped frame deframer: byte stream in, checked result words out.
`timescale 1ns / 1ps

module escaped_frame_deframer_tb;

    import efd_pkg::*;

    // The run stops here if the stream never drains. The limit leaves a wide margin
    // over what a correct run needs.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // The block holds a byte in its input register; this pause covers bytes that give no word.
    localparam int unsigned DRAIN_CYCLES = 6;
    // Roughly how many line bytes each random phase queues.
    localparam int unsigned PHASE_BYTES = 180;
    // One long receiver hold-off starts after this many result words.
    localparam int unsigned HOLD_AFTER = 150;
    localparam int unsigned HOLD_CYCLES = 400;

    // A line byte waiting to be sent, with the idle cycles the sender spends before it.
    typedef struct {
        logic [7:0]  value;
        int unsigned gap;
    } line_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       type_limit_we = 1'b0;
    logic [7:0] type_limit_wdata = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
    logic [7:0] frame_type;
    logic       type_known;
    logic       dangling_escape;

    // Bytes still to be sent and result words still to be seen.
    line_word_t  line_words[$];
    efd_result_t expected_words[$];

    // The testbench's own copy of the decoder state and of the type limit register.
    phase_t      deframe_phase = PH_HUNT;
    logic [7:0]  frame_type_hold = 8'd0;
    logic [7:0]  type_limit_copy = TYPE_LIMIT_RESET;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_queued = 0;
    int unsigned gap_count = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned results_seen = 0;
    line_word_t  next_word;
    efd_result_t want_word;

    escaped_frame_deframer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .type_limit_we    (type_limit_we),
        .type_limit_wdata (type_limit_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .is_data          (is_data),
        .frame_end        (frame_end),
        .frame_type       (frame_type),
        .type_known       (type_known),
        .dangling_escape  (dangling_escape)
    );

    always #10 clk = ~clk;

    // Cycle counter that ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("escaped_frame_deframer_tb failed");
            $finish;
        end
    end

    // Steps the expected decoder by one accepted line byte. A payload word or a frame
    // end word is appended to the expected list; other bytes only move the state.
    task automatic predict_deframe(input logic [7:0] b);
        efd_result_t word;
        logic        gives_word;
        logic        known;
        begin
            word = '0;
            gives_word = 1'b0;
            known = (frame_type_hold != 8'd0) && (frame_type_hold < type_limit_copy);
            case (deframe_phase)
                PH_HUNT:
                begin
                    // Anything but a start byte is line noise between frames.
                    if (b == START_CODE)
                        deframe_phase = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (b == STOP_CODE)
                    begin
                        // Empty frame: the end word carries a zero, unknown type.
                        frame_type_hold = 8'd0;
                        deframe_phase = PH_HUNT;
                        word.frame_end = 1'b1;
                        gives_word = 1'b1;
                    end
                    else
                    begin
                        // The type byte is kept raw, even a start or escape byte.
                        frame_type_hold = b;
                        deframe_phase = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (b == STOP_CODE)
                    begin
                        deframe_phase = PH_HUNT;
                        word.frame_end = 1'b1;
                        word.frame_type = frame_type_hold;
                        word.type_known = known;
                        gives_word = 1'b1;
                    end
                    else if (b == ESC_CODE)
                    begin
                        deframe_phase = PH_ESC;
                    end
                    else
                    begin
                        // A start byte inside a frame is plain payload.
                        word.out_byte = b;
                        word.is_data = 1'b1;
                        word.frame_type = frame_type_hold;
                        word.type_known = known;
                        gives_word = 1'b1;
                    end
                end
                default:
                begin
                    word.frame_type = frame_type_hold;
                    word.type_known = known;
                    gives_word = 1'b1;
                    if (b == STOP_CODE)
                    begin
                        // The stop still closes the frame, and the open escape is flagged.
                        deframe_phase = PH_HUNT;
                        word.frame_end = 1'b1;
                        word.dangling_escape = 1'b1;
                    end
                    else
                    begin
                        // The escaped byte is added to the escape code modulo 256, so a
                        // second escape gives zero and does not open another escape.
                        deframe_phase = PH_BODY;
                        word.out_byte = ESC_CODE + b;
                        word.is_data = 1'b1;
                    end
                end
            endcase
            if (gives_word)
                expected_words.push_back(word);
        end
    endtask

    // Sender. A word is predicted when it is accepted; the next byte goes out once its
    // gap has been spent. With a zero gap valid simply stays high for the next word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'd0;
            gap_count = 0;
            deframe_phase = PH_HUNT;
            frame_type_hold = 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_deframe(rx_byte);
            if (!in_valid || in_ready)
            begin
                if (line_words.size() != 0 && gap_count >= line_words[0].gap)
                begin
                    next_word = line_words.pop_front();
                    in_valid <= 1'b1;
                    rx_byte <= next_word.value;
                    gap_count = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (line_words.size() != 0)
                        gap_count++;
                end
            end
        end
    end

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Receiver. Each accepted word is checked against the oldest expectation, then a
    // stall is drawn for the next one. Some stretches run with no stalls at all, and
    // once the receiver holds off long enough for the block to fill and stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, out_byte %02h is_data %b frame_end %b",
                             $time, out_byte, is_data, frame_end);
                    error_count++;
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    check_field("out_byte", want_word.out_byte, out_byte);
                    check_field("is_data", want_word.is_data, is_data);
                    check_field("frame_end", want_word.frame_end, frame_end);
                    check_field("frame_type", want_word.frame_type, frame_type);
                    check_field("type_known", want_word.type_known, type_known);
                    check_field("dangling_escape", want_word.dangling_escape,
                                dangling_escape);
                end
                results_seen++;
                if ((results_seen % 200) < 60)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 9);
                if (results_seen == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] value, input int unsigned gap_max);
        line_word_t word;
        begin
            word.value = value;
            word.gap = $urandom_range(0, gap_max);
            line_words.push_back(word);
            bytes_queued++;
        end
    endtask

    // One random frame, mostly well formed. Types lean toward the edges of the known
    // range, bodies toward escapes, and a few frames end on an open escape or never end.
    task automatic queue_random_frame();
        int unsigned gap_max;
        int unsigned body_len;
        int unsigned pick;
        logic [7:0]  b;
        begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == START_CODE)
                        b = 8'h7F;
                    queue_byte(b, gap_max);
                end
            end
            queue_byte(START_CODE, gap_max);
            pick = $urandom_range(0, 11);
            case (pick)
                0: b = 8'd0;
                1: b = START_CODE;
                2: b = ESC_CODE;
                3: b = STOP_CODE;
                4: b = type_limit_copy - 8'd1;
                5: b = type_limit_copy;
                6: b = 8'd1;
                default: b = 8'($urandom_range(0, 255));
            endcase
            queue_byte(b, gap_max);
            // A stop byte in the type slot already closed an empty frame.
            if (b != STOP_CODE)
            begin
                body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 8);
                repeat (body_len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        b = ESC_CODE;
                    else if (pick < 20)
                        b = START_CODE;
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == STOP_CODE)
                            b = 8'hFD;
                    end
                    queue_byte(b, gap_max);
                end
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    queue_byte(ESC_CODE, gap_max);
                    queue_byte(STOP_CODE, gap_max);
                end
                else if (pick < 90)
                begin
                    queue_byte(STOP_CODE, gap_max);
                end
            end
        end
    endtask

    // Waits until every byte has been sent and every word seen, then lets bytes that
    // give no word leave the block.
    task automatic wait_for_idle();
        begin
            while (line_words.size() != 0 || in_valid || expected_words.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_type_limit(input logic [7:0] value);
        begin
            @(posedge clk);
            type_limit_we <= 1'b1;
            type_limit_wdata <= value;
            @(posedge clk);
            type_limit_we <= 1'b0;
            type_limit_copy = value;
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] phase_limits[5];
        logic [7:0] directed[$];
        int unsigned phase_end;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset limit of 16. The first frame has type 15, the
        // highest known type, and a body with a plain zero, a start byte as payload,
        // escape-escape, escape-start and escape-7F.
        directed = '{START_CODE, 8'h0F, 8'h00, START_CODE, ESC_CODE, ESC_CODE, ESC_CODE,
                     START_CODE, ESC_CODE, 8'h7F, 8'h41, STOP_CODE,
                     // Noise outside any frame gives nothing.
                     8'h00, ESC_CODE, STOP_CODE,
                     // Empty frame.
                     START_CODE, STOP_CODE,
                     // Escape code as the type, then an escape left open before the stop.
                     START_CODE, ESC_CODE, ESC_CODE, STOP_CODE,
                     // Start code as the type.
                     START_CODE, START_CODE, 8'h7E, STOP_CODE,
                     // Zero type and type 16, both unknown at this limit.
                     START_CODE, 8'h00, STOP_CODE,
                     START_CODE, 8'h10, STOP_CODE};
        foreach (directed[i])
            queue_byte(directed[i], (i < 12) ? 0 : 3);
        wait_for_idle();

        // Random phases, each under its own limit, extremes included.
        phase_limits[0] = 8'd1;
        phase_limits[1] = 8'd255;
        phase_limits[2] = ESC_CODE;
        phase_limits[3] = 8'($urandom_range(2, 254));
        phase_limits[4] = TYPE_LIMIT_RESET;
        foreach (phase_limits[p])
        begin
            write_type_limit(phase_limits[p]);
            phase_end = bytes_queued + PHASE_BYTES + ((p == 4) ? PHASE_BYTES : 0);
            while (bytes_queued < phase_end)
                queue_random_frame();
            wait_for_idle();
        end

        if (expected_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, expected_words.size());
            error_count++;
        end
        if (error_count == 0)
            $display("escaped_frame_deframer_tb passed");
        else
            $display("escaped_frame_deframer_tb failed");
        $finish;
    end

endmodule
